FILE: hdl/mrb_pkg.sv
// shared constants, types and helpers for the max rectangle core
`default_nettype none
package mrb_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;
   localparam int CFG_W        = 7;
   localparam int AREA_W       = 13;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
   localparam logic [AREA_W-1:0] AREA_MAX  = 13'h1FFF;

   typedef enum logic [0:0] {
      REG_ROW_COUNT = 1'b0,
      REG_COL_COUNT = 1'b1
   } csr_index_type;

   // classification of one cell made by the front end
   typedef struct packed {
      logic cell_bit;
      logic last_col;
      logic last_mat;
   } cell_tag_type;

   // a zero count acts as one, a count above the limit acts as the limit
   function automatic int eff_count(input logic [CFG_W-1:0] value, input int limit);
      int v;
      v = int'(value);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mrb_front.sv
// front end: takes cells, tracks row and column position, tags row and matrix ends
`default_nettype none
module mrb_front
   import mrb_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   localparam int ColW = $clog2(MAX_COLS),
   localparam int RowW = $clog2(MAX_ROWS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic [ColW:0]     eff_cols,
   input  wire logic [RowW:0]     eff_rows,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cell_bit,
   input  wire logic              q_full,
   output logic                   q_wr,
   output cell_tag_type           q_tag,
   output logic [ColW-1:0]        q_col
);

   logic [ColW-1:0] col_pos_ff, col_pos_in;
   logic [RowW-1:0] row_pos_ff, row_pos_in;
   logic            last_col;
   logic            last_row;

   assign req_ready = !q_full;
   assign q_wr      = req_valid && !q_full;

   assign last_col = {1'b0, col_pos_ff} == (eff_cols - (ColW+1)'(1));
   assign last_row = {1'b0, row_pos_ff} == (eff_rows - (RowW+1)'(1));

   assign q_tag.cell_bit = req_cell_bit;
   assign q_tag.last_col = last_col;
   assign q_tag.last_mat = last_col && last_row;
   assign q_col          = col_pos_ff;

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (clear) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (q_wr) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : row_pos_ff + RowW'(1);
         end else begin
            col_pos_in = col_pos_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mrb_queue.sv
// short fifo between front end and stack engine
`default_nettype none
module mrb_queue
   import mrb_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PtrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    cnt_ff, cnt_in;

   assign full    = cnt_ff == (PtrW+1)'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         cnt_in    = '0;
      end else begin
         if (wr_en) begin
            wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (rd_en) begin
            rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         case ({wr_en, rd_en})
            2'b10:   cnt_in = cnt_ff + (PtrW+1)'(1);
            2'b01:   cnt_in = cnt_ff - (PtrW+1)'(1);
            default: cnt_in = cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mrb_back.sv
// stack engine: column heights, monotonic index stack, area scoring, result register
`default_nettype none
module mrb_back
   import mrb_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   localparam int ColW = $clog2(MAX_COLS),
   localparam int CntW = ColW + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic [CntW-1:0]   eff_cols,
   input  wire logic              q_empty,
   output logic                   q_rd,
   input  wire cell_tag_type      q_tag,
   input  wire logic [ColW-1:0]   q_col,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [AREA_W-1:0]      rsp_max_area
);

   localparam int HgtW = $clog2(MAX_ROWS + 1);
   localparam int PrdW = HgtW + CntW;
   localparam int CmpW = (PrdW > AREA_W) ? PrdW : AREA_W;
   localparam int EntW = ColW + HgtW;
   localparam logic [HgtW-1:0] HgtMax = HgtW'(MAX_ROWS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CALC  = 5'b00010,
      ST_STACK = 5'b00100,
      ST_FILL  = 5'b01000,
      ST_EMIT  = 5'b10000
   } back_state_type;

   back_state_type      state_ff, state_in;
   cell_tag_type        tag_ff;
   logic [ColW-1:0]     col_ff;
   logic [HgtW-1:0]     h_cur_ff;
   logic                drain_ff, drain_in;

   logic [HgtW-1:0]     hgt_mem [MAX_COLS];
   logic [HgtW-1:0]     hgt_rd_ff;
   logic                hgt_rd_vld_ff;
   logic [MAX_COLS-1:0] hgt_vld_ff;

   logic [EntW-1:0]     stk_mem [MAX_COLS];
   logic [EntW-1:0]     stk_rd_ff;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [ColW-1:0]     top_idx_ff, top_idx_in, blw_idx_ff, blw_idx_in;
   logic [HgtW-1:0]     top_h_ff, top_h_in, blw_h_ff, blw_h_in;

   logic [PrdW-1:0]     area_ff;
   logic                area_vld_ff, area_vld_in;
   logic [AREA_W-1:0]   best_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]   rsp_area_ff;

   logic [HgtW-1:0]     h_prev;
   logic [HgtW-1:0]     h_new;
   logic                hgt_we;
   logic                stk_we;
   logic [CntW-1:0]     cnt_dec;
   logic [CntW-1:0]     cnt_sub3;
   logic [CntW-1:0]     pos;
   logic [CntW-1:0]     width;
   logic                do_pop;
   logic                emit_go;
   logic [CmpW-1:0]     area_ext;
   logic [AREA_W-1:0]   area_sat;

   assign q_rd         = (state_ff == ST_IDLE) && !q_empty && !clear;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;

   // height update of the current column, saturating at the row limit
   assign h_prev = hgt_rd_vld_ff ? hgt_rd_ff : '0;
   always_comb begin
      if (!tag_ff.cell_bit) begin
         h_new = '0;
      end else if (h_prev >= HgtMax) begin
         h_new = HgtMax;
      end else begin
         h_new = h_prev + HgtW'(1);
      end
   end

   assign cnt_dec  = cnt_ff - CntW'(1);
   assign cnt_sub3 = cnt_ff - CntW'(3);
   assign pos      = drain_ff ? eff_cols : {1'b0, col_ff};
   assign width    = (cnt_ff >= CntW'(2)) ? pos - {1'b0, blw_idx_ff} - CntW'(1) : pos;
   assign do_pop   = (cnt_ff != '0) && (drain_ff || (top_h_ff > h_cur_ff));
   assign emit_go  = !rsp_valid_ff || rsp_ready;

   assign hgt_we = (state_ff == ST_CALC) && !clear;
   assign stk_we = (state_ff == ST_STACK) && !do_pop && !drain_ff && (cnt_ff != '0) && !clear;

   assign area_ext = CmpW'(area_ff);
   assign area_sat = (area_ext > CmpW'(AREA_MAX)) ? AREA_MAX : area_ext[AREA_W-1:0];

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      cnt_in       = cnt_ff;
      top_idx_in   = top_idx_ff;
      top_h_in     = top_h_ff;
      blw_idx_in   = blw_idx_ff;
      blw_h_in     = blw_h_ff;
      area_vld_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_STACK;
         end
         ST_STACK: begin
            if (do_pop) begin
               // score the top, the entry below becomes the new top
               area_vld_in = 1'b1;
               cnt_in      = cnt_dec;
               top_idx_in  = blw_idx_ff;
               top_h_in    = blw_h_ff;
               if (cnt_ff >= CntW'(3)) begin
                  state_in = ST_FILL;
               end
            end else if (!drain_ff) begin
               if (cnt_ff != '0) begin
                  blw_idx_in = top_idx_ff;
                  blw_h_in   = top_h_ff;
               end
               top_idx_in = col_ff;
               top_h_in   = h_cur_ff;
               cnt_in     = cnt_ff + CntW'(1);
               if (tag_ff.last_col) begin
                  drain_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               drain_in = 1'b0;
               state_in = tag_ff.last_mat ? ST_EMIT : ST_IDLE;
            end
         end
         ST_FILL: begin
            blw_idx_in = stk_rd_ff[EntW-1 -: ColW];
            blw_h_in   = stk_rd_ff[HgtW-1:0];
            state_in   = ST_STACK;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clear) begin
         state_in    = ST_IDLE;
         drain_in    = 1'b0;
         cnt_in      = '0;
         area_vld_in = 1'b0;
      end
   end

   // column height memory with one valid bit per column
   always_ff @(posedge clock) begin
      if (hgt_we) begin
         hgt_mem[col_ff] <= h_new;
      end
      hgt_rd_ff <= hgt_mem[q_col];
   end

   // stack memory holds every entry below the cached top
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_dec[ColW-1:0]] <= {top_idx_ff, top_h_ff};
      end
      stk_rd_ff <= stk_mem[cnt_sub3[ColW-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_rd) begin
         tag_ff <= q_tag;
         col_ff <= q_col;
      end
      if (state_ff == ST_CALC) begin
         h_cur_ff <= h_new;
      end
      top_idx_ff <= top_idx_in;
      top_h_ff   <= top_h_in;
      blw_idx_ff <= blw_idx_in;
      blw_h_ff   <= blw_h_in;
      area_ff    <= {{CntW{1'b0}}, top_h_ff} * {{HgtW{1'b0}}, width};
      if ((state_ff == ST_EMIT) && emit_go) begin
         rsp_area_ff <= best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         drain_ff      <= 1'b0;
         cnt_ff        <= '0;
         area_vld_ff   <= 1'b0;
         best_ff       <= '0;
         hgt_vld_ff    <= '0;
         hgt_rd_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         cnt_ff       <= cnt_in;
         area_vld_ff  <= area_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_rd) begin
            hgt_rd_vld_ff <= hgt_vld_ff[q_col];
         end
         if (clear || ((state_ff == ST_EMIT) && emit_go)) begin
            best_ff    <= '0;
            hgt_vld_ff <= '0;
         end else begin
            if (area_vld_ff && (area_sat > best_ff)) begin
               best_ff <= area_sat;
            end
            if (hgt_we) begin
               hgt_vld_ff[col_ff] <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: hdl/max_rectangle_binary_matrix_core.sv
// top level of the largest all-ones rectangle core
//
// cells of a binary matrix enter on the req_ channel, one item each, in
// row-major order; any nonzero cell_bit counts as a set cell. after the last
// cell of row_count rows by col_count columns one item leaves on the rsp_
// channel carrying the largest all-ones rectangle area, then all matrix state
// is cleared for the next matrix.
// csr_ writes set row_count (index 0) and col_count (index 1); either write
// also restarts the matrix. a zero count acts as one, a count above the
// parameter limit acts as the limit.
// an item passes the IDLE, CALC and STACK states of the stack engine, and
// each stack pop adds a STACK step (pops needing a refill of the cached
// entry from stack memory also pass FILL); each row ends with a final
// STACK step. each column is pushed and popped once per row.
// the last score goes via area_ff and best_ff into the result register.
// a 4-deep queue lets cells keep arriving while the engine works.
// reset sets both counts to 64 and clears heights, stack and best area.
// a stalled rsp_ channel holds the result in the output register while the
// next matrix is processed; the engine waits only when a second result is due.
`default_nettype none
module max_rectangle_binary_matrix_core
   import mrb_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cell_bit,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [AREA_W-1:0]      rsp_max_area,
   input  wire logic              csr_wr_en,
   input  wire logic [0:0]        csr_index,
   input  wire logic [CFG_W-1:0]  csr_wr_data
);

   localparam int ColW  = $clog2(MAX_COLS);
   localparam int RowW  = $clog2(MAX_ROWS);
   localparam int TagW  = $bits(cell_tag_type);
   localparam int QueW  = TagW + ColW;

   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [CFG_W-1:0] col_count_ff, col_count_in;
   logic             clear;
   logic [ColW:0]    eff_cols;
   logic [RowW:0]    eff_rows;

   // front end to queue
   logic             q_wr;
   logic             q_full;
   cell_tag_type     f_tag;
   logic [ColW-1:0]  f_col;

   // queue to stack engine
   logic             q_rd;
   logic             q_empty;
   logic [QueW-1:0]  q_data;
   cell_tag_type     b_tag;
   logic [ColW-1:0]  b_col;

   // configuration registers; every write starts a fresh matrix
   assign clear = csr_wr_en;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_ROW_COUNT: row_count_in = csr_wr_data;
            REG_COL_COUNT: col_count_in = csr_wr_data;
            default:       row_count_in = row_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_RESET;
         col_count_ff <= CFG_RESET;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // clamped counts: columns go to both sides, rows to the front end only
   assign eff_cols = (ColW+1)'(eff_count(col_count_ff, MAX_COLS));
   assign eff_rows = (RowW+1)'(eff_count(row_count_ff, MAX_ROWS));

   mrb_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .clear        (clear),
      .eff_cols     (eff_cols),
      .eff_rows     (eff_rows),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cell_bit (req_cell_bit),
      .q_full       (q_full),
      .q_wr         (q_wr),
      .q_tag        (f_tag),
      .q_col        (f_col)
   );

   mrb_queue #(
      .WIDTH (QueW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr_en   (q_wr),
      .wr_data ({f_tag, f_col}),
      .full    (q_full),
      .rd_en   (q_rd),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   assign b_tag = cell_tag_type'(q_data[QueW-1 -: TagW]);
   assign b_col = q_data[ColW-1:0];

   mrb_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .clear        (clear),
      .eff_cols     (eff_cols),
      .q_empty      (q_empty),
      .q_rd         (q_rd),
      .q_tag        (b_tag),
      .q_col        (b_col),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_max_area (rsp_max_area)
   );

endmodule
`default_nettype wire
